// ===== src/spip_pkg.sv =====
// Shared types and constants for the scanline point-in-polygon block.
// No dependencies; compile this file first.
`default_nettype none

package spip_pkg;

  // Default coordinate width of the edge and point fields.
  localparam int COORD_BITS_DEF = 24;

  // Crossing counters wrap modulo 2^CNT_BITS.
  localparam int CNT_BITS = 13;

  typedef logic [CNT_BITS-1:0] cnt_t;

  // Per-edge control bits carried alongside the datapath.
  typedef struct packed {
    logic spans;    // closed y span of the edge contains the scanline
    logic dy_zero;  // horizontal edge
    logic dy_neg;   // edge runs downward
    logic last;     // closing edge of the polygon
  } edge_flags_t;

endpackage

`default_nettype wire

// ===== src/spip_in_if.sv =====
// Edge channel: valid/ready handshake with query point and one polygon edge.
// Depends on spip_pkg.
`default_nettype none

interface spip_in_if import spip_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) ();

  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;
  logic signed [CoordBits-1:0] edge_x_start;
  logic signed [CoordBits-1:0] edge_y_start;
  logic signed [CoordBits-1:0] edge_x_end;
  logic signed [CoordBits-1:0] edge_y_end;
  logic                        last_edge;

  modport source (
    output valid, point_x, point_y, edge_x_start, edge_y_start,
           edge_x_end, edge_y_end, last_edge,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, edge_x_start, edge_y_start,
           edge_x_end, edge_y_end, last_edge,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/spip_out_if.sv =====
// Result channel: valid/ready handshake with the inside/outside verdict.
// Depends on spip_pkg.
`default_nettype none

interface spip_out_if import spip_pkg::*; ();

  logic valid;
  logic ready;
  logic inside_res;
  logic odd_crossings;
  cnt_t crossing_total;

  modport source (
    output valid, inside_res, odd_crossings, crossing_total,
    input  ready
  );

  modport sink (
    input  valid, inside_res, odd_crossings, crossing_total,
    output ready
  );

endinterface

`default_nettype wire

// ===== src/scanline_point_in_polygon.sv =====
// Crossing-number point-in-polygon test, one polygon edge per item.
// Depends on spip_pkg, spip_in_if and spip_out_if.
`default_nettype none

// Streams one polygon edge per cycle, unless stalled as below, and reports one
// verdict per polygon, on the edge marked last_edge. Each edge passes three
// registers: the input register holds the endpoint differences and span test,
// the product register holds the two signed 2*(COORD_BITS+1)-bit products that
// place the crossing relative to point_x, and the counters plus the result
// register take the comparison. A new edge is accepted while earlier edges are
// still in flight. The edge channel stays ready while a verdict waits to be
// taken, and stalls only when a closing edge reaches the counters with the
// previous verdict still untaken. Crossing counts wrap modulo 8192; parity, and
// so the verdict, is unaffected. The counters clear after every closing edge.
module scanline_point_in_polygon import spip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spip_in_if.sink   edges,
  spip_out_if.source verdict
);

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;

  // Input register
  logic                        valid1;
  edge_flags_t                 flags1;
  logic signed [DIFF_BITS-1:0] a1, b1, c1, d1;

  // Product register
  logic                        valid2;
  edge_flags_t                 flags2;
  logic signed [PROD_BITS-1:0] p1, p2;

  // Accumulated state and result register
  cnt_t total_count, left_count;
  logic touch_flag;
  logic out_valid;
  logic out_inside;
  logic out_odd;
  cnt_t out_total;

  // Sign-extended operands at the input
  logic signed [DIFF_BITS-1:0] pxw, pyw, xsw, ysw, xew, yew;
  logic signed [DIFF_BITS-1:0] a_next, b_next, c_next, d_next;
  edge_flags_t                 flags_next;

  logic out_free, consume2, load2, move1, take_in;
  logic is_left, is_touch;
  cnt_t total_next, left_next;
  logic touch_next;
  logic signed [PROD_BITS-1:0] p1_next, p2_next;

  // Handshake chain: each stage moves when the one after it has room.
  always_comb begin
    out_free = !out_valid || verdict.ready;
    consume2 = valid2 && (!flags2.last || out_free);
    load2    = !valid2 || consume2;
    move1    = valid1 && load2;
    take_in  = edges.valid && edges.ready;
  end

  assign edges.ready = !valid1 || load2;

  // Differences against the first endpoint and the scanline span test.
  always_comb begin
    pxw = {edges.point_x[COORD_BITS-1], edges.point_x};
    pyw = {edges.point_y[COORD_BITS-1], edges.point_y};
    xsw = {edges.edge_x_start[COORD_BITS-1], edges.edge_x_start};
    ysw = {edges.edge_y_start[COORD_BITS-1], edges.edge_y_start};
    xew = {edges.edge_x_end[COORD_BITS-1], edges.edge_x_end};
    yew = {edges.edge_y_end[COORD_BITS-1], edges.edge_y_end};
    a_next = pyw - ysw;
    b_next = xew - xsw;
    c_next = pxw - xsw;
    d_next = yew - ysw;
    flags_next.spans   = ((ysw <= pyw) && (pyw <= yew)) || ((yew <= pyw) && (pyw <= ysw));
    flags_next.dy_zero = (d_next == '0);
    flags_next.dy_neg  = d_next[DIFF_BITS-1];
    flags_next.last    = edges.last_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (take_in) begin
      valid1 <= 1'b1;
    end else if (move1) begin
      valid1 <= 1'b0;
    end
    if (take_in) begin
      flags1 <= flags_next;
      a1     <= a_next;
      b1     <= b_next;
      c1     <= c_next;
      d1     <= d_next;
    end
  end

  // sign(xcross - px) = sign(a*b - c*d) * sign(dy)
  always_comb begin
    p1_next = PROD_BITS'(a1) * PROD_BITS'(b1);
    p2_next = PROD_BITS'(c1) * PROD_BITS'(d1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (load2) begin
      valid2 <= valid1;
    end
    if (move1) begin
      flags2 <= flags1;
      p1     <= p1_next;
      p2     <= p2_next;
    end
  end

  // Classify the crossing and fold it into the counts.
  always_comb begin
    is_left  = flags2.spans && !flags2.dy_zero && (flags2.dy_neg ? (p1 > p2) : (p1 < p2));
    is_touch = flags2.spans && !flags2.dy_zero && (p1 == p2);
    total_next = total_count + cnt_t'(flags2.spans);
    left_next  = left_count + cnt_t'(is_left);
    touch_next = touch_flag || is_touch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      left_count  <= '0;
      touch_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (consume2) begin
        if (flags2.last) begin
          // Closing edge: drop the counts for the next polygon.
          total_count <= '0;
          left_count  <= '0;
          touch_flag  <= 1'b0;
        end else begin
          total_count <= total_next;
          left_count  <= left_next;
          touch_flag  <= touch_next;
        end
      end
      if (consume2 && flags2.last) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (consume2 && flags2.last) begin
      out_odd    <= total_next[0];
      out_inside <= !total_next[0] && (touch_next || left_next[0]);
      out_total  <= total_next;
    end
  end

  assign verdict.valid          = out_valid;
  assign verdict.inside_res     = out_inside;
  assign verdict.odd_crossings  = out_odd;
  assign verdict.crossing_total = out_total;

endmodule

`default_nettype wire

// ===== src/spip_checker.sv =====
// Port-level checks for scanline_point_in_polygon, attached by bind.
// Depends on spip_pkg and the top level's interface ports.
`default_nettype none

module spip_checker import spip_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic inside_res,
  input logic odd_crossings,
  input cnt_t crossing_total
);

  // A verdict held back by the sink stays up and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crossing_total)
      && $stable(inside_res) && $stable(odd_crossings))
    else $error("spip: verdict changed while stalled");

  // The odd flag is the parity of the reported total.
  a_odd_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> odd_crossings == crossing_total[0])
    else $error("spip: odd_crossings disagrees with crossing_total");

  // An odd crossing count always forces outside.
  a_odd_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && odd_crossings |-> !inside_res)
    else $error("spip: odd count reported inside");

  // Reset empties the pipeline: no verdict and a ready edge channel next cycle.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("spip: pipeline not empty after reset");

endmodule

bind scanline_point_in_polygon spip_checker u_spip_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (edges.ready),
  .out_valid      (verdict.valid),
  .out_ready      (verdict.ready),
  .inside_res     (verdict.inside_res),
  .odd_crossings  (verdict.odd_crossings),
  .crossing_total (verdict.crossing_total)
);

`default_nettype wire
